// ----- src/udba_pkg.sv -----
// Shared constants and types for the ultrasonic distance band averager.
// Depends on nothing; every other file in src imports it.

package udba_pkg;

    // Number of distances collected before one averaged result is produced.
    localparam int SAMPLES  = 10;
    localparam int IDX_W    = $clog2(SAMPLES);
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int LAST_IDX = SAMPLES - 1;
    localparam int MID_LO   = (SAMPLES - 1) / 2;
    localparam int MID_HI   = SAMPLES / 2;

    localparam int TIMER_W  = 16;
    localparam int WRAP_W   = 8;
    localparam int TEMP_W   = 10;
    localparam int SAMPLE_W = 16;
    localparam int TICKS_W  = 24;
    localparam int SPEED_W  = 16;
    localparam int PROD_W   = TICKS_W + SPEED_W;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int LIM_W    = 24;

    // Shared divider geometry: 16 quotient bits, saturating.
    localparam int DIVIDEND_W = PROD_W;
    localparam int DIVISOR_W  = 22;
    localparam int QUOT_W     = 16;
    localparam int STEP_W     = $clog2(QUOT_W);

    localparam int TICKS_PER_WRAP = 65535;
    localparam int TICK_SCALE     = 625;
    localparam int SOUND_BASE     = 33160;
    localparam int SOUND_SLOPE    = 6;
    localparam int TEMP_RESET     = 200;
    localparam int LOW_PCT        = 95;
    localparam int HIGH_PCT       = 105;
    localparam int PCT            = 100;

    // ticks * 625 * speed / 2 / 10^9 folds into one floor division.
    localparam int CONV_DIVISOR = (1000000000 / TICK_SCALE) * 2;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic [IDX_W-1:0]    raddr;
    } store_req_t;

endpackage

// ----- src/udba_div.sv -----
// Shared restoring divider, one quotient bit per cycle, saturating at all ones.
// Depends on udba_pkg for operand and quotient widths.

module udba_div
    import udba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVIDEND_W-1:0] rem_next;
    logic [DIVIDEND_W-1:0] dsh_reg;
    logic [DIVIDEND_W-1:0] dsh_next;
    logic [QUOT_W-1:0]     quot_reg;
    logic [QUOT_W-1:0]     quot_next;
    logic [DIVIDEND_W-1:0] limit;

    // Any dividend at or above divisor * 2^16 gives a quotient that does not fit.
    assign limit = DIVIDEND_W'({divisor, {QUOT_W{1'b0}}});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (start)
        begin
            if (dividend >= limit)
            begin
                quot_next = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = dividend;
                dsh_next  = DIVIDEND_W'({divisor, {(QUOT_W - 1){1'b0}}});
                quot_next = '0;
                step_next = STEP_W'(QUOT_W - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next  = rem_reg - dsh_reg;
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- src/udba_store.sv -----
// Sample memory: one write port and one registered read port.
// Depends on udba_pkg for the depth, widths and request structure.

module udba_store
    import udba_pkg::*;
(
    input  logic                clk,
    input  store_req_t          req,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [SAMPLES];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ultrasonic_distance_band_average.sv -----
// Top level of the ultrasonic distance band averager: sequencer and datapath.
// Depends on udba_pkg, udba_store and udba_div.
//
// Usage: each input transaction carries one echo width (timer_count plus
// overflow_count wraps of 65535 ticks). The block converts it to millimetres
// using the sound speed set by temperature_tenths, and keeps the samples in
// ascending order by inserting each one as it arrives. The transaction that
// completes a set of SAMPLES gives one output transaction, average_mm: the mean
// over the band around the median. Other inputs give no output.
// The block takes one item at a time and holds in_stall high while it works.
// A non-completing item holds in_stall through the multiply, the conversion
// division and the insertion, which reads and moves each larger sample up one
// place; the completing item adds the median, band scan, summing and mean
// division. Conversion and mean use the shared divider, and every read goes
// through the single memory read port.
// The result sits in an output register, so a stalled receiver only holds up
// the block when the next set completes before the previous result is taken.
// The configuration channel is always ready; write it only while idle.
// Reset empties the set, drops any pending result and sets the temperature to
// 20.0 degrees.

module ultrasonic_distance_band_average
    import udba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIMER_W-1:0]  timer_count,
    input  logic [WRAP_W-1:0]   overflow_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] average_mm,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TEMP_W-1:0]   temperature_tenths
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_MUL       = 5'd1;
    localparam logic [4:0] S_CONV_GO   = 5'd2;
    localparam logic [4:0] S_CONV_WAIT = 5'd3;
    localparam logic [4:0] S_INS       = 5'd4;
    localparam logic [4:0] S_INS_CMP   = 5'd5;
    localparam logic [4:0] S_MID0      = 5'd6;
    localparam logic [4:0] S_MID1      = 5'd7;
    localparam logic [4:0] S_MID2      = 5'd8;
    localparam logic [4:0] S_LIM       = 5'd9;
    localparam logic [4:0] S_SCAN_RD   = 5'd10;
    localparam logic [4:0] S_SCAN_CMP  = 5'd11;
    localparam logic [4:0] S_SUM_RD    = 5'd12;
    localparam logic [4:0] S_SUM_ACC   = 5'd13;
    localparam logic [4:0] S_MEAN_GO   = 5'd14;
    localparam logic [4:0] S_MEAN_WAIT = 5'd15;
    localparam logic [4:0] S_OUT       = 5'd16;

    logic [4:0]          state_reg;
    logic [4:0]          state_next;
    logic [IDX_W-1:0]    count_reg;
    logic [IDX_W-1:0]    count_next;
    logic [SPEED_W-1:0]  speed_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] avg_next;

    logic [TICKS_W-1:0]  ticks_reg;
    logic [TICKS_W-1:0]  ticks_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [SAMPLE_W-1:0] d_reg;
    logic [SAMPLE_W-1:0] d_next;
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    j_next;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    i_next;
    logic [IDX_W-1:0]    lo_reg;
    logic [IDX_W-1:0]    lo_next;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    hi_next;
    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] a_next;
    logic [SAMPLE_W-1:0] m_reg;
    logic [SAMPLE_W-1:0] m_next;
    logic [LIM_W-1:0]    lo_lim_reg;
    logic [LIM_W-1:0]    lo_lim_next;
    logic [LIM_W-1:0]    hi_lim_reg;
    logic [LIM_W-1:0]    hi_lim_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] res_reg;
    logic [SAMPLE_W-1:0] res_next;

    store_req_t            store_req;
    logic [SAMPLE_W-1:0]   store_rdata;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;

    logic                  in_accept;
    logic                  out_load;
    logic                  low_hit;
    logic                  high_hit;
    logic [IDX_W-1:0]      lo_upd;
    logic [SAMPLE_W:0]     mid_sum;

    udba_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    udba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // The band limits are compared against 100*s so that no division by 100 is
    // needed: s < floor(a/100) holds exactly when 100*(s+1) <= a, and
    // s > floor(a/100) holds exactly when 100*s > a.
    assign low_hit  = (LIM_W'(PCT) * (LIM_W'(store_rdata) + LIM_W'(1))) <= lo_lim_reg;
    assign high_hit = (LIM_W'(PCT) * LIM_W'(store_rdata)) > hi_lim_reg;
    assign lo_upd   = low_hit ? i_reg : lo_reg;
    assign mid_sum  = {1'b0, a_reg} + {1'b0, store_rdata};

    assign div_start = (state_reg == S_CONV_GO) || (state_reg == S_MEAN_GO);

    always_comb
    begin
        if (state_reg == S_MEAN_GO)
        begin
            div_dividend = DIVIDEND_W'(sum_reg);
            div_divisor  = DIVISOR_W'(hi_reg - CNT_W'(lo_reg));
        end
        else
        begin
            div_dividend = prod_reg;
            div_divisor  = DIVISOR_W'(CONV_DIVISOR);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ticks_next  = ticks_reg;
        prod_next   = prod_reg;
        d_next      = d_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        m_next      = m_reg;
        lo_lim_next = lo_lim_reg;
        hi_lim_next = hi_lim_reg;
        sum_next    = sum_reg;
        res_next    = res_reg;
        out_load    = 1'b0;

        store_req.we    = 1'b0;
        store_req.waddr = j_reg;
        store_req.wdata = d_reg;
        store_req.raddr = j_reg - IDX_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ticks_next = TICKS_W'(timer_count)
                               + TICKS_W'(overflow_count) * TICKS_W'(TICKS_PER_WRAP);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(ticks_reg) * PROD_W'(speed_reg);
                state_next = S_CONV_GO;
            end
            S_CONV_GO:
            begin
                state_next = S_CONV_WAIT;
            end
            S_CONV_WAIT:
            begin
                if (div_done)
                begin
                    d_next     = div_quot;
                    j_next     = count_reg;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (j_reg == '0)
                begin
                    store_req.we = 1'b1;
                    if (count_reg == IDX_W'(LAST_IDX))
                    begin
                        count_next = '0;
                        state_next = S_MID0;
                    end
                    else
                    begin
                        count_next = count_reg + IDX_W'(1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                store_req.we = 1'b1;
                if (store_rdata > d_reg)
                begin
                    // Shift the larger neighbour up one place and keep looking.
                    store_req.wdata = store_rdata;
                    j_next          = j_reg - IDX_W'(1);
                    state_next      = S_INS;
                end
                else if (count_reg == IDX_W'(LAST_IDX))
                begin
                    count_next = '0;
                    state_next = S_MID0;
                end
                else
                begin
                    count_next = count_reg + IDX_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_MID0:
            begin
                store_req.raddr = IDX_W'(MID_LO);
                state_next      = S_MID1;
            end
            S_MID1:
            begin
                store_req.raddr = IDX_W'(MID_HI);
                a_next          = store_rdata;
                state_next      = S_MID2;
            end
            S_MID2:
            begin
                m_next     = mid_sum[SAMPLE_W:1];
                state_next = S_LIM;
            end
            S_LIM:
            begin
                lo_lim_next = LIM_W'(m_reg) * LIM_W'(LOW_PCT);
                hi_lim_next = LIM_W'(m_reg) * LIM_W'(HIGH_PCT);
                i_next      = '0;
                lo_next     = '0;
                hi_next     = CNT_W'(SAMPLES);
                state_next  = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                store_req.raddr = i_reg;
                state_next      = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                lo_next = lo_upd;
                if (!low_hit && high_hit)
                begin
                    hi_next    = CNT_W'(i_reg) + CNT_W'(1);
                    i_next     = lo_reg;
                    sum_next   = '0;
                    state_next = S_SUM_RD;
                end
                else if (i_reg == IDX_W'(LAST_IDX))
                begin
                    i_next     = lo_upd;
                    sum_next   = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SUM_RD:
            begin
                store_req.raddr = i_reg;
                state_next      = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                sum_next = sum_reg + SUM_W'(store_rdata);
                if ((CNT_W'(i_reg) + CNT_W'(1)) == hi_reg)
                begin
                    state_next = S_MEAN_GO;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_MEAN_GO:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        avg_next       = avg_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            avg_next       = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            speed_reg     <= SPEED_W'(SOUND_BASE + SOUND_SLOPE * TEMP_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                speed_reg <= SPEED_W'(SOUND_BASE)
                           + SPEED_W'(SOUND_SLOPE) * SPEED_W'(temperature_tenths);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg    <= avg_next;
        ticks_reg  <= ticks_next;
        prod_reg   <= prod_next;
        d_reg      <= d_next;
        j_reg      <= j_next;
        i_reg      <= i_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        a_reg      <= a_next;
        m_reg      <= m_next;
        lo_lim_reg <= lo_lim_next;
        hi_lim_reg <= hi_lim_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign average_mm = avg_reg;

endmodule

// ----- src/udba_checker.sv -----
// Port-level checker for the ultrasonic distance band averager, with its bind.
// Depends on udba_pkg for port widths.

module udba_checker
    import udba_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [SAMPLE_W-1:0] average_mm
);

    // An accepted transaction keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

    // A new result is only produced by work in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

    // A result cannot follow straight on from the transaction that starts work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared one cycle after an input");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(average_mm)))
    else $error("stalled result changed or was dropped");

endmodule

bind ultrasonic_distance_band_average udba_checker u_checker (.*);

// ----- verif/ultrasonic_distance_band_average_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_distance_band_average. A scoreboard class predicts
// each band-filtered average from the accepted echoes; tasks drive input and config.
// Depends on udba_pkg and the block's RTL in src.

module ultrasonic_distance_band_average_tb;
    import udba_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int HOLD_OFF_CYCLES = 2500;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 150;
    localparam int TAIL_CYCLES     = 200;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 131;
    localparam int MAX_REPORTS     = 10;
    localparam int DIRECTED_N      = 25;
    localparam int TICKS_MAX       = 256 * TICKS_PER_WRAP - 1;

    // First set: a cluster near one metre with low outliers and two saturated echoes.
    // Second set: all zero distances. Then a partial set of saturated echoes.
    localparam logic [TIMER_W-1:0] DIRECTED_TIMER [DIRECTED_N] = '{
        16'd0, 16'd65535, 16'd27597, 16'd27000, 16'd28000,
        16'd27500, 16'd27700, 16'd27597, 16'd0, 16'd65535,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
        16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535
    };
    localparam logic [WRAP_W-1:0] DIRECTED_WRAPS [DIRECTED_N] = '{
        8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd255, 8'd255,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    class band_average_scoreboard;
        logic [TEMP_W-1:0]   temperature;
        logic [SAMPLE_W-1:0] collected [SAMPLES];
        int unsigned         collected_n;
        logic [SAMPLE_W-1:0] expected_averages [$];
        int unsigned         echoes_seen;
        int unsigned         averages_checked;
        int unsigned         errors;

        function new();
            temperature      = TEMP_W'(TEMP_RESET);
            collected_n      = 0;
            echoes_seen      = 0;
            averages_checked = 0;
            errors           = 0;
        endfunction

        function void flag_error(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, what);
        endfunction

        function logic [SAMPLE_W-1:0] echo_to_mm(logic [TIMER_W-1:0] tc,
                                                 logic [WRAP_W-1:0] oc);
            longint unsigned ticks;
            longint unsigned speed;
            longint unsigned mm;
            ticks = tc + oc * TICKS_PER_WRAP;
            speed = SOUND_BASE + SOUND_SLOPE * temperature;
            mm    = ticks * TICK_SCALE * speed / 2 / 1000000000;
            return (mm > 65535) ? 16'hFFFF : mm[SAMPLE_W-1:0];
        endfunction

        // Stores one accepted echo; the echo that completes a set yields one expected average.
        function void note_echo(logic [TIMER_W-1:0] tc, logic [WRAP_W-1:0] oc);
            logic [SAMPLE_W-1:0] v;
            int          j;
            int unsigned median;
            int unsigned low_limit;
            int unsigned high_limit;
            int unsigned first;
            int unsigned last;
            int unsigned sum;
            bit          high_seen;
            echoes_seen++;
            collected[collected_n] = echo_to_mm(tc, oc);
            collected_n++;
            if (collected_n == SAMPLES) begin
                for (int i = 1; i < SAMPLES; i++) begin
                    v = collected[i];
                    j = i;
                    while (j > 0 && collected[j-1] > v) begin
                        collected[j] = collected[j-1];
                        j--;
                    end
                    collected[j] = v;
                end
                median     = (collected[(SAMPLES-1)/2] + collected[SAMPLES/2]) / 2;
                low_limit  = median * LOW_PCT / PCT;
                high_limit = median * HIGH_PCT / PCT;
                first      = 0;
                last       = SAMPLES;
                high_seen  = 1'b0;
                // The window runs from the last low outlier to the first high one, inclusive.
                for (int i = 0; i < SAMPLES; i++) begin
                    if (!high_seen) begin
                        if (collected[i] < low_limit) begin
                            first = i;
                        end
                        else if (collected[i] > high_limit) begin
                            last      = i + 1;
                            high_seen = 1'b1;
                        end
                    end
                end
                sum = 0;
                for (int i = first; i < last; i++)
                    sum += collected[i];
                v = SAMPLE_W'(sum / (last - first));
                expected_averages.push_back(v);
                collected_n = 0;
            end
        endfunction

        function void check_average(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] wanted;
            if (expected_averages.size() == 0) begin
                flag_error($sformatf("average_mm %0d arrived with no set completed", actual));
            end
            else begin
                wanted = expected_averages.pop_front();
                averages_checked++;
                if (wanted !== actual)
                    flag_error($sformatf("average_mm expected %0d, got %0d", wanted, actual));
            end
        endfunction
    endclass

    logic                clk                = 1'b0;
    logic                rst_n              = 1'b0;
    logic                in_valid           = 1'b0;
    logic                in_stall;
    logic [TIMER_W-1:0]  timer_count        = '0;
    logic [WRAP_W-1:0]   overflow_count     = '0;
    logic                out_valid;
    logic                out_stall          = 1'b0;
    logic [SAMPLE_W-1:0] average_mm;
    logic                cfg_valid          = 1'b0;
    logic                cfg_ready;
    logic [TEMP_W-1:0]   temperature_tenths = '0;

    band_average_scoreboard sb = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_requests  = 0;
    int hold_off_served    = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;

    ultrasonic_distance_band_average dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .timer_count        (timer_count),
        .overflow_count     (overflow_count),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .average_mm         (average_mm),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .temperature_tenths (temperature_tenths)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_off_requests != hold_off_served) begin
            hold_off_served = hold_off_requests;
            hold_left       = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Result checking and the watchdog on cycles with no transaction at all.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_average(average_mm);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("ultrasonic_distance_band_average_tb failed");
                $finish;
            end
        end
    end

    task automatic send_echo(input logic [TIMER_W-1:0] tc, input logic [WRAP_W-1:0] oc);
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid       <= 1'b1;
        timer_count    <= tc;
        overflow_count <= oc;
        do @(posedge clk); while (in_stall);
        sb.note_echo(tc, oc);
    endtask

    task automatic write_temperature(input logic [TEMP_W-1:0] value);
        @(negedge clk);
        cfg_valid          <= 1'b1;
        temperature_tenths <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.temperature = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // An echo that completes no set may still be in conversion, hence the settling pause.
    task automatic drain(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_averages.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        logic [TEMP_W-1:0]  phase_temp [NUM_PHASES];
        idle_mode_t         phase_mode [NUM_PHASES];
        logic [TIMER_W-1:0] tc;
        logic [WRAP_W-1:0]  oc;
        int unsigned        echo_centre;
        int unsigned        jitter;
        int unsigned        ticks;
        int unsigned        r;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_echo(DIRECTED_TIMER[i], DIRECTED_WRAPS[i]);

        phase_temp = '{10'd0, 10'd1023, 10'd1000, 10'd200, 10'd0, 10'd0, 10'd1, 10'd1023};
        phase_temp[5] = TEMP_W'($urandom_range(1023));
        phase_temp[3] = TEMP_W'($urandom_range(1000));
        phase_mode = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                       IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        echo_centre = 93132;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain(SETTLE_CYCLES);
            write_temperature(phase_temp[p]);
            case (phase_mode[p])
                IDLE_SENDER:   begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
                IDLE_BOTH:     begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
                default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            endcase
            // The sender keeps offering during the hold-off, so the block backs up.
            if (p == 4)
                hold_off_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % SAMPLES == 0) begin
                    if ($urandom_range(9) == 0)
                        echo_centre = $urandom_range(TICKS_MAX, 2000);
                    else
                        echo_centre = $urandom_range(1500000, 2000);
                end
                r = $urandom_range(99);
                if (r < 15) begin
                    tc = TIMER_W'($urandom);
                    oc = ($urandom_range(3) == 0) ? WRAP_W'($urandom)
                                                  : WRAP_W'($urandom_range(2));
                end
                else begin
                    jitter = echo_centre / 40 + 1;
                    if (r < 75)
                        ticks = echo_centre - jitter + $urandom_range(2 * jitter);
                    else if (r < 88)
                        ticks = $urandom_range(echo_centre * 9 / 10);
                    else
                        ticks = echo_centre * 11 / 10 + $urandom_range(echo_centre);
                    if (ticks > TICKS_MAX)
                        ticks = TICKS_MAX;
                    tc = TIMER_W'(ticks % TICKS_PER_WRAP);
                    oc = WRAP_W'(ticks / TICKS_PER_WRAP);
                end
                send_echo(tc, oc);
            end
        end

        drain(TAIL_CYCLES);
        if (sb.expected_averages.size() != 0)
            sb.flag_error($sformatf("%0d averages never arrived", sb.expected_averages.size()));

        $display("Run covered %0d echoes and %0d checked averages over %0d temperature settings,",
                 sb.echoes_seen, sb.averages_checked, NUM_PHASES + 1);
        $display("with idle, stall, combined and long hold-off phases; %0d error(s).", sb.errors);
        if (sb.errors == 0) begin
            $display("ultrasonic_distance_band_average_tb passed");
        end
        else begin
            $display("ultrasonic_distance_band_average_tb failed");
        end
        $finish;
    end

endmodule
